// ----- sv/fpa_pkg.sv -----
// Shared types and helpers for the fixed-point ALU.
// No dependencies; imported by every module of the block.
package fpa_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 8;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_NE      = 4'd6,
        OP_EQ      = 4'd7,
        OP_GE      = 4'd8,
        OP_LE      = 4'd9,
        OP_INC     = 4'd10,
        OP_DEC     = 4'd11,
        OP_MAX     = 4'd12,
        OP_MIN     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } t_op;

    // Side data that rides along the divider chain
    typedef struct packed {
        t_op                op;
        logic               qneg;
        logic [DATA_W-1:0]  res;
        logic               cmp;
        logic               ovf;
        logic [PROD_W-1:0]  prod;
    } t_side;

    localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;

    // Saturate a sign and magnitude to 32-bit signed; returns {ovf, value}
    function automatic logic [DATA_W:0] sat_signmag(input logic neg,
                                                     input logic [PROD_W-1:0] mag);
        logic [PROD_W-1:0] lim;
        logic [DATA_W-1:0] val;
        logic              ovf;
        lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        ovf = (mag > lim);
        if (ovf) begin
            val = neg ? MIN_VAL : MAX_VAL;
        end else begin
            val = neg ? (32'd0 - mag[DATA_W-1:0]) : mag[DATA_W-1:0];
        end
        return {ovf, val};
    endfunction

endpackage

// ----- sv/fpa_front.sv -----
// Input stage: decodes the opcode, finishes the non-multiply, non-divide ops,
// forms the product and the divider operands. Depends on fpa_pkg.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [3:0]             i_opcode,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DATA_W-1:0]      o_rem,
    output logic [DATA_W+FRAC-1:0] o_nq,
    output logic [DATA_W-1:0]      o_den,
    output t_side                  o_side
);
    localparam int QW = DATA_W + FRAC;

    logic                   r_valid;
    logic [QW-1:0]          r_nq;
    logic [DATA_W-1:0]      r_den;
    t_side                  r_side;
    t_side                  n_side;

    logic [DATA_W:0]        sum;
    logic signed [DATA_W:0] addend;
    logic signed [QW-1:0]   shl;
    logic [FRAC:0]          upper;
    logic [DATA_W-1:0]      abs_a;
    logic [DATA_W-1:0]      abs_b;
    t_op                    op;

    assign op      = t_op'(i_opcode);
    assign o_ready = !r_valid || i_ready;
    assign abs_a   = i_a[DATA_W-1] ? (32'd0 - i_a) : i_a;
    assign abs_b   = i_b[DATA_W-1] ? (32'd0 - i_b) : i_b;

    // Evaluate the non-multiply, non-divide ops
    always_comb begin
        case (op)
            OP_SUB:  addend = -$signed({i_b[DATA_W-1], i_b});
            OP_INC:  addend = 33'sd1;
            OP_DEC:  addend = -33'sd1;
            default: addend = $signed({i_b[DATA_W-1], i_b});
        endcase
        sum   = $signed({i_a[DATA_W-1], i_a}) + addend;
        shl   = $signed({{FRAC{i_a[DATA_W-1]}}, i_a}) <<< FRAC;
        upper = shl[QW-1:DATA_W-1];

        n_side      = '0;
        n_side.op   = op;
        n_side.qneg = i_a[DATA_W-1] ^ i_b[DATA_W-1];
        n_side.prod = 64'(i_a) * 64'(i_b);
        case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                n_side.ovf = sum[DATA_W] != sum[DATA_W-1];
                n_side.res = n_side.ovf ? (sum[DATA_W] ? MIN_VAL : MAX_VAL)
                                        : sum[DATA_W-1:0];
            end
            OP_GT:   n_side.cmp = i_a > i_b;
            OP_LT:   n_side.cmp = i_a < i_b;
            OP_NE:   n_side.cmp = i_a != i_b;
            OP_EQ:   n_side.cmp = i_a == i_b;
            OP_GE:   n_side.cmp = i_a >= i_b;
            OP_LE:   n_side.cmp = i_a <= i_b;
            OP_MAX:  n_side.res = (i_a >= i_b) ? i_a : i_b;
            OP_MIN:  n_side.res = (i_a <= i_b) ? i_a : i_b;
            OP_TOINT: n_side.res = i_a >>> FRAC;
            OP_FROMINT: begin
                n_side.ovf = !((&upper) || !(|upper));
                n_side.res = n_side.ovf ? (i_a[DATA_W-1] ? MIN_VAL : MAX_VAL)
                                        : shl[DATA_W-1:0];
            end
            default: n_side.res = '0;
        endcase
    end

    // Hold the stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= n_side;
            r_nq   <= {abs_a, {FRAC{1'b0}}};
            r_den  <= abs_b;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_side  = r_side;
endmodule

// ----- sv/fpa_cell.sv -----
// One restoring-division cell: settles one quotient bit and passes the rest on.
// Depends on fpa_pkg.
module fpa_cell
    import fpa_pkg::*;
#(
    parameter int QW = DATA_W + FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_rem,
    input  logic [QW-1:0]     i_nq,
    input  logic [DATA_W-1:0] i_den,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_rem,
    output logic [QW-1:0]     o_nq,
    output logic [DATA_W-1:0] o_den,
    output t_side             o_side
);
    logic              r_valid;
    logic [DATA_W-1:0] r_rem;
    logic [QW-1:0]     r_nq;
    logic [DATA_W-1:0] r_den;
    t_side             r_side;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign o_ready = !r_valid || i_ready;

    // Shift in the next numerator bit and try the subtract
    assign trial = {i_rem, i_nq[QW-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            r_nq   <= {i_nq[QW-2:0], ge};
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_side  = r_side;
endmodule

// ----- sv/fpa_back.sv -----
// Output stage: rounds and saturates multiply and divide, holds the result beat.
// Depends on fpa_pkg.
module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_W-1:0]      i_rem,
    input  logic [DATA_W+FRAC-1:0] i_nq,
    input  logic [DATA_W-1:0]      i_den,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DATA_W-1:0]      o_result,
    output logic                   o_cmp,
    output logic                   o_ovf,
    output logic                   o_dz
);
    localparam int QW = DATA_W + FRAC;

    logic              r_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_cmp;
    logic              r_ovf;
    logic              r_dz;
    logic [DATA_W-1:0] n_result;
    logic              n_ovf;
    logic              n_dz;

    logic [PROD_W-1:0] pmag;
    logic [PROD_W-1:0] pround;
    logic              rup;
    logic [QW:0]       qr;
    logic [DATA_W:0]   sat;

    assign o_ready = !r_valid || i_ready;

    // Round the product and the quotient to nearest, ties away from zero
    always_comb begin
        pmag   = i_side.prod[PROD_W-1] ? (64'd0 - i_side.prod) : i_side.prod;
        pround = (pmag + (64'd1 << (FRAC - 1))) >> FRAC;
        rup    = {i_rem, 1'b0} >= {1'b0, i_den};
        qr     = {1'b0, i_nq} + {{QW{1'b0}}, rup};
        n_result = i_side.res;
        n_ovf    = i_side.ovf;
        n_dz     = 1'b0;
        sat      = '0;
        case (i_side.op)
            OP_MUL: begin
                sat      = sat_signmag(i_side.prod[PROD_W-1], pround);
                n_result = sat[DATA_W-1:0];
                n_ovf    = sat[DATA_W];
            end
            OP_DIV: begin
                if (i_den == '0) begin
                    n_dz     = 1'b1;
                    n_result = '0;
                    n_ovf    = 1'b0;
                end else begin
                    sat      = sat_signmag(i_side.qneg,
                                           {{(PROD_W-QW-1){1'b0}}, qr});
                    n_result = sat[DATA_W-1:0];
                    n_ovf    = sat[DATA_W];
                end
            end
            default: n_dz = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
            r_cmp    <= i_side.cmp;
            r_ovf    <= n_ovf;
            r_dz     <= n_dz;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_cmp    = r_cmp;
    assign o_ovf    = r_ovf;
    assign o_dz     = r_dz;
endmodule

// ----- sv/fixed_point_alu_q24_8_top.sv -----
// Signed Q24.8 fixed-point ALU, top level.
// The pipeline is one decode stage, one division cell per quotient bit,
// and one rounding and output stage.
// Throughput is one beat per cycle while m_axis_tready does not hold the output back.
// Synchronous active-low reset clears all stage valid bits; nothing else.
// Depends on fpa_pkg, fpa_front, fpa_cell and fpa_back.
module fixed_point_alu_q24_8_top
    import fpa_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[3:0], operand_a[35:4], operand_b[67:36], zero pad [71:68]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[31:0]
    output logic [31:0] m_axis_tdata,
    // compare_true[0], overflow[1], divide_by_zero[2]
    output logic [2:0]  m_axis_tuser
);
    localparam int QW = DATA_W + FRAC;

    logic              valid [QW+1];
    logic              ready [QW+1];
    logic [DATA_W-1:0] rem   [QW+1];
    logic [QW-1:0]     nq    [QW+1];
    logic [DATA_W-1:0] den   [QW+1];
    t_side             side  [QW+1];

    fpa_front #(.FRAC(FRAC)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tdata[3:0]),
        .i_a      (s_axis_tdata[35:4]),
        .i_b      (s_axis_tdata[67:36]),
        .o_valid  (valid[0]),
        .i_ready  (ready[0]),
        .o_rem    (rem[0]),
        .o_nq     (nq[0]),
        .o_den    (den[0]),
        .o_side   (side[0])
    );

    // Chain one division cell per quotient bit
    for (genvar k = 0; k < QW; k++) begin : g_cell
        fpa_cell #(.QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_rem   (rem[k]),
            .i_nq    (nq[k]),
            .i_den   (den[k]),
            .i_side  (side[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_rem   (rem[k+1]),
            .o_nq    (nq[k+1]),
            .o_den   (den[k+1]),
            .o_side  (side[k+1])
        );
    end

    fpa_back #(.FRAC(FRAC)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[QW]),
        .o_ready  (ready[QW]),
        .i_rem    (rem[QW]),
        .i_nq     (nq[QW]),
        .i_den    (den[QW]),
        .i_side   (side[QW]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (m_axis_tdata),
        .o_cmp    (m_axis_tuser[0]),
        .o_ovf    (m_axis_tuser[1]),
        .o_dz     (m_axis_tuser[2])
    );

`ifndef ASSERT_OFF
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("divide by zero beat with nonzero result or overflow");
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("compare beat carries result or overflow");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
        else $error("compare and divide-by-zero both set");
`endif
endmodule
